FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Included by the files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FFA_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// Next-cycle implication, disabled during reset
`define FFA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

FILE: rtl/core/ffa_pkg.sv
// Shared types and constants for the first-fit free-list allocator.
// No dependencies; used by ffa_hdr_ram and first_fit_free_list_allocator.
package ffa_pkg;

   // parameter defaults
   localparam int ARENA_UNITS_DEF = 1024;
   localparam int UNIT_BYTES_DEF  = 16;

   // fixed field widths
   localparam int REQ_BYTES_W = 16;
   localparam int PAYLOAD_W   = 10;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 16;

   // unit-count divider: bytes + UNIT_BYTES - 1 needs 17 bits
   localparam int DIV_W = 17;

   // opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_IGNORED  = 2'd2;

   // header field write enables
   typedef struct packed {
      logic next_en;
      logic size_en;
   } hdr_wen_type;

   // sequencer states
   typedef enum logic [3:0] {
      CLEAR,
      IDLE,
      DIVIDE,
      A_ROVER,
      A_LINK,
      A_SCAN,
      A_CARVE,
      F_HEAD,
      F_SIZE,
      F_SCAN,
      F_BOUNDS,
      F_UPPER,
      F_LOWER,
      REPLY
   } state_type;

endpackage

FILE: rtl/core/ffa_hdr_ram.sv
// Header store: one next link and one size per arena unit.
// One write port with per-field enables, one registered read port; uses ffa_pkg.
module ffa_hdr_ram #(
   parameter int DEPTH = ffa_pkg::ARENA_UNITS_DEF,
   parameter int AW    = $clog2(ffa_pkg::ARENA_UNITS_DEF)
) (
   input  logic                     clock,
   input  ffa_pkg::hdr_wen_type     wen,
   input  logic [AW-1:0]            waddr,
   input  logic [AW-1:0]            wnext,
   input  logic [AW-1:0]            wsize,
   input  logic [AW-1:0]            raddr,
   output logic [AW-1:0]            rd_next,
   output logic [AW-1:0]            rd_size
);

   logic [AW-1:0] next_mem [DEPTH];
   logic [AW-1:0] size_mem [DEPTH];
   logic [AW-1:0] rd_next_ff;
   logic [AW-1:0] rd_size_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wen.next_en) begin
         next_mem[waddr] <= wnext;
      end
      if (wen.size_en) begin
         size_mem[waddr] <= wsize;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_next_ff <= next_mem[raddr];
      rd_size_ff <= size_mem[raddr];
   end

   assign rd_next = rd_next_ff;
   assign rd_size = rd_size_ff;

endmodule

FILE: rtl/core/first_fit_free_list_allocator.sv
// First-fit allocator over a fixed arena of ARENA_UNITS header units, with a roving
// free list kept in address order. After reset a clearing pass writes every header,
// one unit a cycle, and takes no word until the pass ends. One word is worked at a
// time and the request side is ready only while idle. An allocate turns bytes into
// units with a reciprocal multiply (DIVIDE), fetches the rover link (A_ROVER, A_LINK),
// then visits one free block per cycle (a single header read port sets that pace),
// a full lap of the list when nothing fits, writes the carved tail's header when the
// block is split (A_CARVE) and posts the result. A free checks for a null or
// out-of-range address and a bad size (F_HEAD, F_SIZE), walks one free block per
// cycle to the insertion point, checks for overlap (F_BOUNDS), merges (F_UPPER,
// F_LOWER) and posts the result; null and bad frees post early. A finished result
// sits in an output register, so the next word is taken while it waits; a later
// result holds in REPLY until that register empties. Allocate answers the payload
// unit address (header plus one) or no-space; a null or bad free gets status ignored.
// Depends on ffa_pkg, ffa_hdr_ram and assert_macros.svh.
`include "assert_macros.svh"

module first_fit_free_list_allocator #(
   parameter int ARENA_UNITS = ffa_pkg::ARENA_UNITS_DEF,
   parameter int UNIT_BYTES  = ffa_pkg::UNIT_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: request_bytes [15:0], block_addr [25:16], zero [31:26]
   input  logic [ffa_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // tuser: opcode [0]
   input  logic                               req_tuser,
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: payload_addr [9:0], status [11:10], zero [15:12]
   output logic [ffa_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int AW     = $clog2(ARENA_UNITS);
   localparam int AW1    = AW + 1;
   localparam int CNT_W  = (AW1 > 5) ? AW1 : 5;
   localparam int CW     = (AW > ffa_pkg::DIV_W) ? AW : ffa_pkg::DIV_W;
   localparam int BW     = ((AW > ffa_pkg::PAYLOAD_W) ? AW : ffa_pkg::PAYLOAD_W) + 1;
   localparam int DIV_W  = ffa_pkg::DIV_W;
   localparam int PAY_W  = ffa_pkg::PAYLOAD_W;
   localparam int ST_W   = ffa_pkg::STATUS_W;
   localparam int BYTE_W = ffa_pkg::REQ_BYTES_W;

   // reciprocal of UNIT_BYTES, exact floor for any dividend below 2**DIV_W
   localparam int     DIV_SH = DIV_W + $clog2(UNIT_BYTES);
   localparam int     MUL_W  = DIV_W + 1;
   localparam int     PRD_W  = DIV_W + MUL_W;
   localparam longint RECIP  = ((longint'(1) << DIV_SH) + longint'(UNIT_BYTES) - 1)
                               / longint'(UNIT_BYTES);

   ffa_pkg::state_type state_ff, state_in;

   logic [AW-1:0]    clr_ff, clr_in;
   logic [AW-1:0]    rover_ff, rover_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             op_ff, op_in;
   logic [PAY_W-1:0] addr_ff, addr_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [AW-1:0]    prev_ff, prev_in;
   logic [AW-1:0]    cur_ff, cur_in;
   logic [AW-1:0]    blk_ff, blk_in;
   logic [AW-1:0]    sz_ff, sz_in;
   logic [AW-1:0]    nx_ff, nx_in;
   logic [AW-1:0]    psz_ff, psz_in;
   logic [AW-1:0]    bsz_ff, bsz_in;
   logic [AW-1:0]    bnx_ff, bnx_in;
   logic [PAY_W-1:0] res_addr_ff, res_addr_in;
   logic [ST_W-1:0]  res_stat_ff, res_stat_in;
   logic [PAY_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [ST_W-1:0]  rsp_stat_ff, rsp_stat_in;

   // header store port
   ffa_pkg::hdr_wen_type wen;
   logic [AW-1:0] waddr, wnext, wsize, raddr, rd_next, rd_size;

   // datapath terms
   logic [BYTE_W-1:0] req_bytes;
   logic [DIV_W-1:0]  dividend;
   logic [MUL_W-1:0]  recip;
   logic [PRD_W-1:0]  prod;
   logic [DIV_W-1:0]  unit_cnt;
   logic              fit, exact;
   logic [AW-1:0]     left_size;
   logic [BW-1:0]     blk_wide;
   logic              blk_bad;
   logic              size_bad;
   logic              between;
   logic              low_overlap, high_overlap;
   logic              upper_merge, lower_merge;

   ffa_hdr_ram #(
      .DEPTH (ARENA_UNITS),
      .AW    (AW)
   ) u_hdr_ram (
      .clock   (clock),
      .wen     (wen),
      .waddr   (waddr),
      .wnext   (wnext),
      .wsize   (wsize),
      .raddr   (raddr),
      .rd_next (rd_next),
      .rd_size (rd_size)
   );

   // byte count to dividend: ceil(max(n,1) / UNIT_BYTES) via floor of n + UNIT_BYTES - 1
   assign req_bytes = req_tdata[BYTE_W-1:0];
   assign dividend  = DIV_W'((req_bytes == '0) ? BYTE_W'(1) : req_bytes)
                      + DIV_W'(UNIT_BYTES - 1);

   // floor division by UNIT_BYTES as multiply and shift
   assign recip    = MUL_W'(RECIP);
   assign prod     = PRD_W'(quo_ff) * PRD_W'(recip);
   assign unit_cnt = DIV_W'(prod >> DIV_SH);

   // fit test against the unit count held in quo_ff
   assign fit       = (CW'(rd_size) >= CW'(quo_ff));
   assign exact     = (CW'(rd_size) == CW'(quo_ff));
   assign left_size = AW'(CW'(rd_size) - CW'(quo_ff));

   // free address range checks
   assign blk_wide = BW'(addr_ff) - BW'(1);
   assign blk_bad  = (blk_wide == '0) || (blk_wide >= BW'(ARENA_UNITS));
   assign size_bad = (rd_size == '0)
                     || (AW1'(rd_size) > (AW1'(ARENA_UNITS) - AW1'(blk_ff)));

   // insertion point test on the header just read at prev_ff
   assign between = ((blk_ff > prev_ff) && (blk_ff < rd_next))
                    || ((prev_ff >= rd_next) && ((blk_ff > prev_ff) || (blk_ff < rd_next)));

   // overlap with free neighbors
   assign low_overlap  = (prev_ff < blk_ff) && ((AW1'(prev_ff) + AW1'(psz_ff)) > AW1'(blk_ff));
   assign high_overlap = (nx_ff > blk_ff) && ((AW1'(blk_ff) + AW1'(sz_ff)) > AW1'(nx_ff));

   // coalesce tests
   assign upper_merge = ((AW1'(blk_ff) + AW1'(sz_ff)) == AW1'(nx_ff));
   assign lower_merge = ((AW1'(prev_ff) + AW1'(psz_ff)) == AW1'(blk_ff));

   // sequencer: next state, store port and datapath updates
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rover_in     = rover_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      quo_in       = quo_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      blk_in       = blk_ff;
      sz_in        = sz_ff;
      nx_in        = nx_ff;
      psz_in       = psz_ff;
      bsz_in       = bsz_ff;
      bnx_in       = bnx_ff;
      res_addr_in  = res_addr_ff;
      res_stat_in  = res_stat_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_stat_in  = rsp_stat_ff;
      wen          = '0;
      waddr        = cur_ff;
      wnext        = '0;
      wsize        = '0;
      raddr        = prev_ff;
      req_tready   = 1'b0;

      // output word taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         // write every header: sentinel, one big free block, zeros elsewhere
         ffa_pkg::CLEAR: begin
            wen.next_en = 1'b1;
            wen.size_en = 1'b1;
            waddr       = clr_ff;
            if (clr_ff == '0) begin
               wnext = AW'(1);
            end else if (clr_ff == AW'(1)) begin
               wsize = AW'(ARENA_UNITS - 1);
            end
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(ARENA_UNITS - 1)) begin
               state_in = ffa_pkg::IDLE;
            end
         end

         ffa_pkg::IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in   = req_tuser;
               addr_in = req_tdata[BYTE_W +: PAY_W];
               quo_in  = dividend;
               cnt_in  = '0;
               if (req_tuser == ffa_pkg::OP_ALLOC) begin
                  state_in = ffa_pkg::DIVIDE;
               end else begin
                  state_in = ffa_pkg::F_HEAD;
               end
            end
         end

         // unit count in one step
         ffa_pkg::DIVIDE: begin
            quo_in   = unit_cnt;
            state_in = ffa_pkg::A_ROVER;
         end

         // add the header unit, fetch the rover
         ffa_pkg::A_ROVER: begin
            quo_in   = quo_ff + DIV_W'(1);
            raddr    = rover_ff;
            prev_in  = rover_ff;
            state_in = ffa_pkg::A_LINK;
         end

         ffa_pkg::A_LINK: begin
            cur_in   = rd_next;
            raddr    = rd_next;
            cnt_in   = '0;
            state_in = ffa_pkg::A_SCAN;
         end

         // one free block per cycle
         ffa_pkg::A_SCAN: begin
            if (fit) begin
               if (exact) begin
                  wen.next_en = 1'b1;
                  waddr       = prev_ff;
                  wnext       = rd_next;
                  rover_in    = prev_ff;
                  res_addr_in = PAY_W'(AW1'(cur_ff) + AW1'(1));
                  res_stat_in = ffa_pkg::STAT_DONE;
                  state_in    = ffa_pkg::REPLY;
               end else begin
                  wen.size_en = 1'b1;
                  waddr       = cur_ff;
                  wsize       = left_size;
                  cur_in      = cur_ff + left_size;
                  state_in    = ffa_pkg::A_CARVE;
               end
            end else if ((cur_ff == rover_ff) || (cnt_ff == CNT_W'(ARENA_UNITS))) begin
               res_addr_in = '0;
               res_stat_in = ffa_pkg::STAT_NO_SPACE;
               state_in    = ffa_pkg::REPLY;
            end else begin
               prev_in = cur_ff;
               cur_in  = rd_next;
               raddr   = rd_next;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end

         // header of the carved tail
         ffa_pkg::A_CARVE: begin
            wen.size_en = 1'b1;
            waddr       = cur_ff;
            wsize       = AW'(quo_ff);
            rover_in    = prev_ff;
            res_addr_in = PAY_W'(AW1'(cur_ff) + AW1'(1));
            res_stat_in = ffa_pkg::STAT_DONE;
            state_in    = ffa_pkg::REPLY;
         end

         // null and out-of-range frees
         ffa_pkg::F_HEAD: begin
            if ((addr_ff == '0) || blk_bad) begin
               res_addr_in = '0;
               res_stat_in = ffa_pkg::STAT_IGNORED;
               state_in    = ffa_pkg::REPLY;
            end else begin
               blk_in   = AW'(blk_wide);
               raddr    = AW'(blk_wide);
               state_in = ffa_pkg::F_SIZE;
            end
         end

         ffa_pkg::F_SIZE: begin
            sz_in = rd_size;
            if (size_bad) begin
               res_addr_in = '0;
               res_stat_in = ffa_pkg::STAT_IGNORED;
               state_in    = ffa_pkg::REPLY;
            end else begin
               raddr    = rover_ff;
               prev_in  = rover_ff;
               cnt_in   = '0;
               state_in = ffa_pkg::F_SCAN;
            end
         end

         // walk to the address-ordered insertion point
         ffa_pkg::F_SCAN: begin
            if (between) begin
               nx_in    = rd_next;
               psz_in   = rd_size;
               state_in = ffa_pkg::F_BOUNDS;
            end else if (cnt_ff == CNT_W'(ARENA_UNITS)) begin
               res_addr_in = '0;
               res_stat_in = ffa_pkg::STAT_IGNORED;
               state_in    = ffa_pkg::REPLY;
            end else begin
               prev_in = rd_next;
               raddr   = rd_next;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end

         // double free or overlap with a free neighbor
         ffa_pkg::F_BOUNDS: begin
            if (low_overlap || high_overlap) begin
               res_addr_in = '0;
               res_stat_in = ffa_pkg::STAT_IGNORED;
               state_in    = ffa_pkg::REPLY;
            end else begin
               raddr    = nx_ff;
               state_in = ffa_pkg::F_UPPER;
            end
         end

         // link to, or merge with, the upper neighbor
         ffa_pkg::F_UPPER: begin
            wen.next_en = 1'b1;
            waddr       = blk_ff;
            if (upper_merge) begin
               wen.size_en = 1'b1;
               wnext       = rd_next;
               wsize       = sz_ff + rd_size;
               bnx_in      = rd_next;
               bsz_in      = sz_ff + rd_size;
            end else begin
               wnext  = nx_ff;
               bnx_in = nx_ff;
               bsz_in = sz_ff;
            end
            state_in = ffa_pkg::F_LOWER;
         end

         // link from, or merge into, the lower neighbor
         ffa_pkg::F_LOWER: begin
            wen.next_en = 1'b1;
            waddr       = prev_ff;
            if (lower_merge) begin
               wen.size_en = 1'b1;
               wnext       = bnx_ff;
               wsize       = psz_ff + bsz_ff;
            end else begin
               wnext = blk_ff;
            end
            rover_in    = prev_ff;
            res_addr_in = '0;
            res_stat_in = ffa_pkg::STAT_DONE;
            state_in    = ffa_pkg::REPLY;
         end

         // post the result once the output register is free
         ffa_pkg::REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = res_addr_ff;
               rsp_stat_in  = res_stat_ff;
               state_in     = ffa_pkg::IDLE;
            end
         end

         default: begin
            state_in = ffa_pkg::IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffa_pkg::CLEAR;
         clr_ff       <= '0;
         rover_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rover_ff     <= rover_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      quo_ff      <= quo_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      blk_ff      <= blk_in;
      sz_ff       <= sz_in;
      nx_ff       <= nx_in;
      psz_ff      <= psz_in;
      bsz_ff      <= bsz_in;
      bnx_ff      <= bnx_in;
      res_addr_ff <= res_addr_in;
      res_stat_ff <= res_stat_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   // output word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(ffa_pkg::RSP_TDATA_W - PAY_W - ST_W){1'b0}}, rsp_stat_ff, rsp_addr_ff};

   // checks
   `FFA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_tvalid && req_tready, state_ff != ffa_pkg::IDLE)
   `FFA_ASSERT_IMPL(a_walk_bounded, clock, reset, (state_ff == ffa_pkg::A_SCAN) || (state_ff == ffa_pkg::F_SCAN), cnt_ff <= CNT_W'(ARENA_UNITS))
   `FFA_ASSERT_IMPL(a_rover_in_arena, clock, reset, state_ff != ffa_pkg::CLEAR, AW1'(rover_ff) < AW1'(ARENA_UNITS))
   `FFA_ASSERT_IMPL(a_fail_no_addr, clock, reset, (state_ff == ffa_pkg::REPLY) && (res_stat_ff != ffa_pkg::STAT_DONE), res_addr_ff == '0)
   `FFA_ASSERT_IMPL(a_alloc_addr, clock, reset, (state_ff == ffa_pkg::REPLY) && (op_ff == ffa_pkg::OP_ALLOC) && (res_stat_ff == ffa_pkg::STAT_DONE), res_addr_ff != '0)

endmodule
